// File: hw/rtl/lsb_stego_payload_extractor_assert.svh
// Assertion macros for the LSB payload extractor.
`ifndef LSB_STEGO_PAYLOAD_EXTRACTOR_ASSERT_SVH
`define LSB_STEGO_PAYLOAD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define LSBSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsbse: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define LSBSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsbse: next-cycle check failed");

`endif

// File: hw/rtl/lsbse_pkg.sv
// Types and constants for the LSB payload extractor.
`timescale 1ns / 1ps

package lsbse_pkg;

    localparam int PIXEL_W = 8;
    localparam int LEN_W   = 32;
    localparam int POS_W   = 3;
    localparam int HDR_W   = 2;

    // Index of the last of the four length header bytes
    localparam logic [HDR_W-1:0] HDR_LAST = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_DONE    = 3'b100
    } phase_t;

endpackage

// File: hw/rtl/lsb_stego_payload_extractor.sv
// Top level of the LSB payload extractor: pixel stream in, hidden payload bytes out.
`timescale 1ns / 1ps

// Recovers a payload hidden in the low EMBED_BITS bits of a pixel byte stream.
// Each group of 8/EMBED_BITS pixels builds one hidden byte, first pixel in the
// least significant bits. The first four hidden bytes are a big-endian 32-bit
// length (all 32 bits kept); the next that-many hidden bytes leave on the
// master side, the final one with tlast set. A length of zero, and any pixel
// after the payload, gives no output. A transaction with tuser set restarts
// extraction at that pixel. The block takes one pixel per clock while the
// output register is free: the input register and the output register are
// each refilled in the same cycle they empty, so throughput is one
// transaction per cycle unless m_tready is held low. The pixel completing a
// payload byte is held in the input register, the byte in the output register.
// The per-pixel path is one mask and shift, a 32-bit increment and compare.
module lsb_stego_payload_extractor
    import lsbse_pkg::*;
#(
    parameter int EMBED_BITS = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIXEL_W-1:0] s_tdata,   // [7:0] pixel_byte
    input  logic               s_tuser,   // [0] start_of_image
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [PIXEL_W-1:0] m_tdata,   // [7:0] hidden_byte
    output logic               m_tlast    // last_byte
);

`include "lsb_stego_payload_extractor_assert.svh"

    localparam int GROUP_LEN = PIXEL_W / EMBED_BITS;
    localparam logic [POS_W-1:0] GROUP_LAST = POS_W'(GROUP_LEN - 1);
    localparam logic [PIXEL_W-1:0] BIT_MASK = PIXEL_W'(8'hff >> (PIXEL_W - EMBED_BITS));

    // Input register
    logic               in_valid_reg;
    logic [PIXEL_W-1:0] pixel_reg;
    logic               start_reg;

    // Extraction state
    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [PIXEL_W-1:0] acc_reg, acc_next;
    logic [HDR_W-1:0]   hdr_reg, hdr_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   sent_reg, sent_next;

    // Output register
    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_data_reg;
    logic               out_last_reg;

    // Working values
    logic               can_proc;
    logic               advance;
    phase_t             phase_cur;
    logic [POS_W-1:0]   pos_cur;
    logic [PIXEL_W-1:0] acc_cur;
    logic [HDR_W-1:0]   hdr_cur;
    logic [LEN_W-1:0]   len_cur;
    logic [LEN_W-1:0]   sent_cur;
    logic [5:0]         shamt_full;
    logic [PIXEL_W-1:0] acc_new;
    logic [LEN_W-1:0]   len_new;
    logic [LEN_W-1:0]   sent_new;
    logic               out_load;
    logic               out_last;

    // Process the held pixel whenever the output register is free this cycle
    assign can_proc = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && can_proc;
    assign s_tready = !in_valid_reg || can_proc;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        // A start flag clears all state before the pixel itself counts
        phase_cur = start_reg ? PH_HEADER : phase_reg;
        pos_cur   = start_reg ? '0 : pos_reg;
        acc_cur   = start_reg ? '0 : acc_reg;
        hdr_cur   = start_reg ? '0 : hdr_reg;
        len_cur   = start_reg ? '0 : len_reg;
        sent_cur  = start_reg ? '0 : sent_reg;

        shamt_full = 6'(pos_cur) * 6'(EMBED_BITS);
        acc_new    = acc_cur | ((pixel_reg & BIT_MASK) << shamt_full[2:0]);
        len_new    = {len_cur[LEN_W-PIXEL_W-1:0], acc_new};
        sent_new   = sent_cur + LEN_W'(1);

        phase_next = phase_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        hdr_next   = hdr_reg;
        len_next   = len_reg;
        sent_next  = sent_reg;
        out_load   = 1'b0;
        out_last   = 1'b0;

        if (advance)
        begin
            phase_next = phase_cur;
            pos_next   = pos_cur;
            acc_next   = acc_cur;
            hdr_next   = hdr_cur;
            len_next   = len_cur;
            sent_next  = sent_cur;

            if (phase_cur != PH_DONE)
            begin
                if (pos_cur != GROUP_LAST)
                begin
                    // Group still filling: accumulate and advance
                    pos_next = pos_cur + POS_W'(1);
                    acc_next = acc_new;
                end
                else
                begin
                    pos_next = '0;
                    acc_next = '0;
                    unique case (phase_cur)
                        PH_HEADER:
                        begin
                            len_next = len_new;
                            if (hdr_cur == HDR_LAST)
                            begin
                                hdr_next   = '0;
                                phase_next = (len_new == '0) ? PH_DONE : PH_PAYLOAD;
                            end
                            else
                            begin
                                hdr_next = hdr_cur + HDR_W'(1);
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            sent_next = sent_new;
                            out_load  = 1'b1;
                            out_last  = (sent_new == len_cur);
                            if (out_last)
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_DONE;
                        end
                    endcase
                end
            end
        end
    end

    // Input register: refill in the cycle it drains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pixel_reg <= s_tdata;
            start_reg <= s_tuser;
        end
    end

    // Extraction state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            acc_reg   <= '0;
            hdr_reg   <= '0;
            len_reg   <= '0;
            sent_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            hdr_reg   <= hdr_next;
            len_reg   <= len_next;
            sent_reg  <= sent_next;
        end
    end

    // Output register: hold until the downstream side takes the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= acc_new;
            out_last_reg <= out_last;
        end
    end

    // Final payload byte always ends extraction
    `LSBSE_ASSERT_NEXT(a_last_ends, clk, rst_n, out_load && out_last, phase_reg == PH_DONE)
    // Payload bytes come only out of the payload phase
    `LSBSE_ASSERT_NOW(a_out_in_payload, clk, rst_n, out_load, phase_cur == PH_PAYLOAD)
    // In the payload phase the length is nonzero and not yet reached
    `LSBSE_ASSERT_NOW(a_payload_bound, clk, rst_n, phase_reg == PH_PAYLOAD, (len_reg != '0) && (sent_reg < len_reg))
    // A partial header count exists only while the header is read
    `LSBSE_ASSERT_NOW(a_hdr_phase, clk, rst_n, hdr_reg != '0, phase_reg == PH_HEADER)

endmodule
